>>> sv/htlp_pkg.sv
`timescale 1ns / 1ps
package htlp_pkg;

    localparam int SLOT_W      = 6;
    localparam int TABLE_SLOTS = 2 ** SLOT_W;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int KEY_BYTES   = 8;
    localparam int FILL_W      = 7;
    localparam logic [FILL_W-1:0] FILL_LIMIT_RESET = 7'd48;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_TOO_FULL  = 3'd2;
    localparam logic [2:0] ST_NO_PLACE  = 3'd3;
    localparam logic [2:0] ST_EMPTY_KEY = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [63:0] value_in;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value_out;
        logic [6:0]  entry_count;
    } out_word_t;

    typedef struct packed {
        logic              used;
        logic [SLOT_W-1:0] home;
        logic [63:0]       key;
        logic [63:0]       value;
    } slot_t;

    // Keeps the bytes before the first zero byte and at most KEY_BYTES of them.
    function automatic logic [63:0] clean_key(input logic [63:0] raw);
        logic [63:0] k;
        logic        live;
        k    = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (raw[8*b +: 8] == 8'd0 || b >= KEY_BYTES) begin
                live = 1'b0;
            end
            if (live) begin
                k[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return k;
    endfunction

endpackage

>>> sv/hash_table_linear_probe_core.sv
`timescale 1ns / 1ps
// Clear, unused action, refused or empty-key words go straight to the done state, which
// loads the result word once the output register is free. Insert and find first hash the
// key byte by byte, rotate the slot ring until the home slot is at the head, then probe
// slot by slot, shift a displaced cluster slot by slot where needed, and load the result.
// One word is handled at a time: s_ready is high only in the idle state.
// Reset (aresetn, synchronous, active low) empties all slots and sets fill_limit to 48.
module hash_table_linear_probe_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  htlp_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output htlp_pkg::out_word_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic [6:0]           cfg_wr_data
);
    import htlp_pkg::*;

    // Controller states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HASH   = 4'd1;
    localparam logic [3:0] S_SEEK   = 4'd2;
    localparam logic [3:0] S_FIND   = 4'd3;
    localparam logic [3:0] S_INS0   = 4'd4;
    localparam logic [3:0] S_SKIP   = 4'd5;
    localparam logic [3:0] S_JLOOP  = 4'd6;
    localparam logic [3:0] S_RIPPLE = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // The table lives in a ring of cells. Cell 0 is the head and holds the slot
    // whose index is offset_reg. Each rotation moves every cell's contents to its
    // lower neighbor, so the head steps to the next slot; the old head wraps to the
    // top cell, and may be replaced on the way by a new slot value.
    slot_t cell_q [TABLE_SLOTS];
    slot_t head;
    slot_t top_in;
    slot_t wdata;
    logic  rot;
    logic  wr;
    logic  clear_all;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        action_reg, action_next;
    logic [63:0]       key_reg, key_next;
    logic [63:0]       val_reg, val_next;
    logic [SLOT_W-1:0] home_reg, home_next;
    logic [SLOT_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FILL_W-1:0] fill_limit_reg;
    slot_t             carry_reg, carry_next;
    logic [2:0]        status_reg, status_next;
    logic [63:0]       vout_reg, vout_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    logic              hash_start;
    logic              hash_done;
    logic [SLOT_W-1:0] hash_home;
    logic [63:0]       in_key;
    logic              key_hit;
    slot_t             new_slot;

    assign head   = cell_q[0];
    assign top_in = wr ? wdata : head;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_ring
            if (gi == TABLE_SLOTS - 1) begin : g_top
                htlp_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (rot),
                    .clear    (clear_all),
                    .slot_in  (top_in),
                    .slot_out (cell_q[gi])
                );
            end else begin : g_mid
                htlp_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (rot),
                    .clear    (clear_all),
                    .slot_in  (cell_q[gi+1]),
                    .slot_out (cell_q[gi])
                );
            end
        end
    endgenerate

    assign in_key = clean_key(s_data.key);

    htlp_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (key_reg),
        .done    (hash_done),
        .home    (hash_home)
    );

    assign key_hit  = (head.key == key_reg);
    assign new_slot = '{used: 1'b1, home: home_reg, key: key_reg, value: val_reg};

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        action_next  = action_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        home_next    = home_reg;
        n_next       = n_reg;
        count_next   = count_reg;
        carry_next   = carry_reg;
        status_next  = status_reg;
        vout_next    = vout_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rot          = 1'b0;
        wr           = 1'b0;
        wdata        = new_slot;
        clear_all    = 1'b0;
        hash_start   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    action_next = s_data.action;
                    key_next    = in_key;
                    val_next    = s_data.value_in;
                    status_next = ST_OK;
                    vout_next   = '0;
                    state_next  = S_DONE;
                    if (s_data.action == ACT_CLEAR) begin
                        clear_all  = 1'b1;
                        count_next = '0;
                    end else if (s_data.action == ACT_INSERT &&
                                 int'(count_reg) > int'(fill_limit_reg)) begin
                        status_next = ST_TOO_FULL;
                    end else if (s_data.action == ACT_INSERT ||
                                 s_data.action == ACT_FIND) begin
                        if (in_key[7:0] == 8'd0) begin
                            status_next = ST_EMPTY_KEY;
                        end else begin
                            state_next = S_HASH;
                        end
                    end
                end
            end
            S_HASH: begin
                // The hash unit is started in the cycle after acceptance, once key_reg holds the key.
                if (hash_done) begin
                    home_next  = hash_home;
                    state_next = S_SEEK;
                end else if (n_reg == '0) begin
                    hash_start = 1'b1;
                    n_next     = CNT_W'(1);
                end
            end
            S_SEEK: begin
                n_next = '0;
                if (offset_reg == home_reg) begin
                    state_next = (action_reg == ACT_FIND) ? S_FIND : S_INS0;
                end else begin
                    rot = 1'b1;
                end
            end
            S_FIND: begin
                if (n_reg == CNT_W'(TABLE_SLOTS) || !head.used) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else if (key_hit) begin
                    vout_next  = head.value;
                    state_next = S_DONE;
                end else begin
                    rot    = 1'b1;
                    n_next = n_reg + CNT_W'(1);
                end
            end
            S_INS0: begin
                if (!head.used) begin
                    rot        = 1'b1;
                    wr         = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end else if (key_hit) begin
                    rot         = 1'b1;
                    wr          = 1'b1;
                    wdata       = head;
                    wdata.value = val_reg;
                    state_next  = S_DONE;
                end else if (head.home == home_reg) begin
                    rot        = 1'b1;
                    n_next     = CNT_W'(1);
                    state_next = S_SKIP;
                end else begin
                    state_next = S_JLOOP;
                end
            end
            S_SKIP: begin
                // Skip the slots of other clusters until this home's run or a gap.
                if (n_reg != CNT_W'(TABLE_SLOTS) && head.used && head.home != home_reg) begin
                    rot    = 1'b1;
                    n_next = n_reg + CNT_W'(1);
                end else begin
                    n_next     = '0;
                    state_next = S_JLOOP;
                end
            end
            S_JLOOP: begin
                if (n_reg == count_reg + CNT_W'(1)) begin
                    status_next = ST_NO_PLACE;
                    state_next  = S_DONE;
                end else if (!head.used) begin
                    rot        = 1'b1;
                    wr         = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end else if (key_hit) begin
                    rot         = 1'b1;
                    wr          = 1'b1;
                    wdata       = head;
                    wdata.value = val_reg;
                    state_next  = S_DONE;
                end else if (head.home != home_reg) begin
                    // A shift needs a free slot somewhere; none exists when the table is full.
                    if (count_reg == CNT_W'(TABLE_SLOTS)) begin
                        status_next = ST_NO_PLACE;
                        state_next  = S_DONE;
                    end else begin
                        rot        = 1'b1;
                        wr         = 1'b1;
                        carry_next = head;
                        state_next = S_RIPPLE;
                    end
                end else begin
                    rot    = 1'b1;
                    n_next = n_reg + CNT_W'(1);
                end
            end
            S_RIPPLE: begin
                // Each displaced slot moves one place forward until a gap takes the last one.
                rot   = 1'b1;
                wr    = 1'b1;
                wdata = carry_reg;
                if (head.used) begin
                    carry_next = head;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                n_next = '0;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.value_out   = vout_reg;
                    m_data_next.entry_count = 7'(count_reg);
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign offset_next = rot ? offset_reg + SLOT_W'(1) : offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            offset_reg     <= '0;
            count_reg      <= '0;
            n_reg          <= '0;
            m_valid_reg    <= 1'b0;
            fill_limit_reg <= FILL_LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            offset_reg  <= offset_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                fill_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        home_reg   <= home_next;
        carry_reg  <= carry_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/htlp_cell.sv
`timescale 1ns / 1ps
module htlp_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  logic           clear,
    input  htlp_pkg::slot_t slot_in,
    output htlp_pkg::slot_t slot_out
);
    import htlp_pkg::*;

    slot_t slot_reg;

    // Only the occupied flag is reset; the payload is meaningful only when it is set.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            slot_reg.used <= 1'b0;
        end else if (shift_en) begin
            slot_reg.used <= slot_in.used;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            slot_reg.home  <= slot_in.home;
            slot_reg.key   <= slot_in.key;
            slot_reg.value <= slot_in.value;
        end
    end

    assign slot_out = slot_reg;

endmodule

>>> sv/htlp_hash.sv
`timescale 1ns / 1ps
module htlp_hash (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [63:0]                key,
    output logic                       done,
    output logic [htlp_pkg::SLOT_W-1:0] home
);
    import htlp_pkg::*;

    logic [31:0] h_reg, h_next;
    logic [3:0]  idx_reg, idx_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [7:0]  cur_byte;
    logic [31:0] t0, t1, f0, f1;

    assign cur_byte = key[8*idx_reg[2:0] +: 8];

    always_comb begin
        t0 = h_reg + {24'd0, cur_byte};
        t0 = t0 + (t0 << 10);
        t1 = t0 ^ (t0 >> 6);
        f0 = h_reg + (h_reg << 3);
        f0 = f0 ^ (f0 >> 11);
        f1 = f0 + (f0 << 15);
    end

    always_comb begin
        h_next    = h_reg;
        idx_next  = idx_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            h_next   = '0;
            idx_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (int'(idx_reg) < KEY_BYTES && cur_byte != 8'd0) begin
                h_next   = t1;
                idx_next = idx_reg + 4'd1;
            end else begin
                h_next    = f1;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg   <= h_next;
        idx_reg <= idx_next;
    end

    assign done = done_reg;
    assign home = h_reg[SLOT_W-1:0];

endmodule

>>> sv/htlp_checker.sv
`timescale 1ns / 1ps
module htlp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input htlp_pkg::out_word_t m_data
);
    import htlp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_EMPTY_KEY &&
                    int'(m_data.entry_count) <= TABLE_SLOTS)
        else $error("result word out of range");

    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.value_out == 64'd0)
        else $error("value returned with a failing status");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An accepted word keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a word was taken");

endmodule

bind hash_table_linear_probe_core htlp_checker u_htlp_checker (.*);

>>> bench/hash_table_linear_probe_core_tb.sv
`timescale 1ns / 1ps
module hash_table_linear_probe_core_tb;
    import htlp_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    logic      cfg_wr_en;
    logic [6:0] cfg_wr_data;

    hash_table_linear_probe_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The predictor's private copy of the table.
    logic [63:0] tbl_key [TABLE_SLOTS];
    logic [63:0] tbl_val [TABLE_SLOTS];
    logic [5:0]  tbl_home [TABLE_SLOTS];
    logic        tbl_used [TABLE_SLOTS];
    int unsigned tbl_count;
    int unsigned fill_cap;

    out_word_t expected_words[$];
    int        mismatches;

    // Key words recently used, so that finds and overwrites hit stored entries.
    logic [63:0] key_pool[$];

    // Trims the key at its first zero byte and folds it into a slot number.
    function automatic logic [63:0] trim_key(input logic [63:0] raw, output logic [5:0] home);
        logic [63:0] k;
        logic [31:0] h;
        k = '0;
        h = '0;
        for (int b = 0; b < 8; b++) begin
            if (raw[8*b +: 8] == 8'd0) break;
            k[8*b +: 8] = raw[8*b +: 8];
            h = h + raw[8*b +: 8];
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        home = h[5:0];
        return k;
    endfunction

    function automatic void put_slot(int p, logic [5:0] home, logic [63:0] k, logic [63:0] v);
        tbl_used[p] = 1'b1;
        tbl_home[p] = home;
        tbl_key[p]  = k;
        tbl_val[p]  = v;
        tbl_count++;
    endfunction

    // Pushes the occupied run that starts at p one slot forward.
    function automatic bit push_run(int p);
        int n;
        n = 1;
        while (n < TABLE_SLOTS && tbl_used[(p + n) % TABLE_SLOTS]) n++;
        if (n >= TABLE_SLOTS) return 1'b0;
        while (n > 0) begin
            tbl_used[(p + n) % TABLE_SLOTS] = 1'b1;
            tbl_home[(p + n) % TABLE_SLOTS] = tbl_home[(p + n - 1) % TABLE_SLOTS];
            tbl_key[(p + n) % TABLE_SLOTS]  = tbl_key[(p + n - 1) % TABLE_SLOTS];
            tbl_val[(p + n) % TABLE_SLOTS]  = tbl_val[(p + n - 1) % TABLE_SLOTS];
            n--;
        end
        tbl_used[p] = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [2:0] place_entry(logic [63:0] k, logic [5:0] home,
                                               logic [63:0] v);
        int p;
        int n;
        int q;
        p = home;
        if (!tbl_used[p]) begin
            put_slot(p, home, k, v);
            return ST_OK;
        end
        if (tbl_key[p] == k) begin
            tbl_val[p] = v;
            return ST_OK;
        end
        if (tbl_home[p] == home) begin
            n = 0;
            do begin
                p = (p + 1) % TABLE_SLOTS;
                n++;
            end while (n < TABLE_SLOTS && tbl_used[p] && tbl_home[p] != home);
        end
        n = tbl_count + 1;
        for (int j = 0; j < n; j++) begin
            q = (p + j) % TABLE_SLOTS;
            if (!tbl_used[q]) begin
                put_slot(q, home, k, v);
                return ST_OK;
            end
            if (tbl_key[q] == k) begin
                tbl_val[q] = v;
                return ST_OK;
            end
            if (tbl_home[q] != home) begin
                if (!push_run(q)) return ST_NO_PLACE;
                put_slot(q, home, k, v);
                return ST_OK;
            end
        end
        return ST_NO_PLACE;
    endfunction

    // Works out the response word for one request and updates the table copy.
    function automatic out_word_t table_response(in_word_t w);
        out_word_t r;
        logic [63:0] k;
        logic [5:0]  home;
        int p;
        r = '0;
        r.status = ST_OK;
        case (w.action)
            ACT_CLEAR: begin
                for (int i = 0; i < TABLE_SLOTS; i++) tbl_used[i] = 1'b0;
                tbl_count = 0;
            end
            ACT_INSERT: begin
                if (tbl_count > fill_cap) begin
                    r.status = ST_TOO_FULL;
                end else begin
                    k = trim_key(w.key, home);
                    if (k == 64'd0) r.status = ST_EMPTY_KEY;
                    else r.status = place_entry(k, home, w.value_in);
                end
            end
            ACT_FIND: begin
                k = trim_key(w.key, home);
                if (k == 64'd0) begin
                    r.status = ST_EMPTY_KEY;
                end else begin
                    r.status = ST_NOT_FOUND;
                    p = home;
                    for (int n = 0; n < TABLE_SLOTS; n++) begin
                        if (!tbl_used[p]) break;
                        if (tbl_key[p] == k) begin
                            r.status = ST_OK;
                            r.value_out = tbl_val[p];
                            break;
                        end
                        p = (p + 1) % TABLE_SLOTS;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = tbl_count[6:0];
        return r;
    endfunction

    // Receiver: stalls on a repeating pattern whose shape changes now and then.
    logic [15:0] stall_mask;
    int          stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_phase <= 0;
            stall_mask  <= 16'hFFFF;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 300 == 299) begin
                case ($urandom_range(0, 3))
                    0: stall_mask <= 16'hFFFF;
                    1: stall_mask <= 16'h0F0F;
                    2: stall_mask <= 16'h8001;
                    default: stall_mask <= 16'($urandom);
                endcase
            end
            m_ready <= stall_mask[stall_phase % 16];
        end
    end

    // Checks every accepted response word against the oldest expected word.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word: status=%0d value=%h count=%0d",
                             m_data.status, m_data.value_out, m_data.entry_count);
            end else begin
                want = expected_words.pop_front();
                if (m_data.status !== want.status || m_data.value_out !== want.value_out ||
                    m_data.entry_count !== want.entry_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: expected status=%0d value=%h count=%0d, got status=%0d value=%h count=%0d",
                                 want.status, want.value_out, want.entry_count,
                                 m_data.status, m_data.value_out, m_data.entry_count);
                end
            end
        end
    end

    // Sends one request word and queues its predicted response at acceptance.
    // Valid stays high after acceptance; the caller drops it before any idle cycle.
    task automatic send_word(in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(table_response(w));
    endtask

    // Like send_word, but also compares the prediction with a typed-in answer.
    task automatic send_known(in_word_t w, logic [2:0] st, logic [6:0] cnt);
        out_word_t p;
        send_word(w);
        p = expected_words[$];
        if (p.status != st || p.entry_count != cnt) begin
            mismatches++;
            $display("table row disagrees with predictor: status %0d/%0d count %0d/%0d",
                     st, p.status, cnt, p.entry_count);
        end
    endtask

    task automatic drain_responses();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_fill_limit(logic [6:0] v);
        drain_responses();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fill_cap = v;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        int len;
        k   = {$urandom, $urandom};
        len = $urandom_range(0, 7);
        // Short keys crowd the table with few distinct homes and many collisions.
        if (len < 7 && $urandom_range(0, 3) != 0) begin
            k[8*($urandom_range(1, 3)) +: 8] = 8'd0;
        end
        if ($urandom_range(0, 40) == 0) k[7:0] = 8'd0;
        return k;
    endfunction

    typedef struct {
        logic [1:0]  action;
        logic [63:0] key;
        logic [63:0] value_in;
        bit          known;
        logic [2:0]  status;
        logic [6:0]  count;
    } stim_row_t;

    stim_row_t rows[$];

    initial begin
        in_word_t w;
        int burst;
        int pick;
        int gap;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        mismatches  = 0;
        tbl_count   = 0;
        fill_cap    = FILL_LIMIT_RESET;
        for (int i = 0; i < TABLE_SLOTS; i++) tbl_used[i] = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: empty table, extremes, every action and the special cases.
        rows = '{
            '{ACT_FIND,   64'h41,                 64'd0,        1, ST_NOT_FOUND, 7'd0},
            '{ACT_INSERT, 64'h0,                  64'd5,        1, ST_EMPTY_KEY, 7'd0},
            '{ACT_FIND,   64'hFFFF_FFFF_FFFF_FF00, 64'd0,       1, ST_EMPTY_KEY, 7'd0},
            '{ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 7'd1},
            '{ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 64'd0,       0, ST_OK,        7'd1},
            '{ACT_INSERT, 64'h01,                 64'd0,        1, ST_OK,        7'd2},
            '{ACT_INSERT, 64'h00FF_0001,          64'h1234,     1, ST_OK,        7'd2},
            '{ACT_FIND,   64'hAB00_0001,          64'd0,        0, ST_OK,        7'd2},
            '{ACT_INSERT, 64'h4142_4344,          64'h55,       1, ST_OK,        7'd3},
            '{ACT_INSERT, 64'h4142_4344,          64'h66,       1, ST_OK,        7'd3},
            '{ACT_FIND,   64'h4142_4344,          64'd0,        0, ST_OK,        7'd3},
            '{ACT_SPARE,  64'h4142_4344,          64'h77,       1, ST_OK,        7'd3},
            '{ACT_FIND,   64'h8080_8080_8080_8080, 64'd0,       1, ST_NOT_FOUND, 7'd3},
            '{ACT_CLEAR,  64'h4142_4344,          64'h99,       1, ST_OK,        7'd0},
            '{ACT_FIND,   64'h4142_4344,          64'd0,        1, ST_NOT_FOUND, 7'd0}
        };
        foreach (rows[i]) begin
            w.action   = rows[i].action;
            w.key      = rows[i].key;
            w.value_in = rows[i].value_in;
            if (rows[i].known) send_known(w, rows[i].status, rows[i].count);
            else send_word(w);
        end

        // A zero fill limit refuses the second insert.
        write_fill_limit(7'd0);
        send_known('{ACT_INSERT, 64'h31, 64'd1}, ST_OK, 7'd1);
        send_known('{ACT_INSERT, 64'h32, 64'd2}, ST_TOO_FULL, 7'd1);

        // Maximum limit: fill every slot, so probes and shifts see a full ring.
        write_fill_limit(7'd127);
        send_word('{ACT_CLEAR, 64'd0, 64'd0});
        for (int i = 0; i < 90; i++) send_word('{ACT_INSERT, 64'h100 + i, {$urandom, $urandom}});
        send_word('{ACT_FIND, 64'h5A5A, 64'd0});
        send_word('{ACT_FIND, 64'h0101, 64'd0});

        // The sender holds off until the table has answered everything.
        drain_responses();

        // Random part: phases with different limits, sent in bursts with gaps (phase 3 in one gapless run).
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_fill_limit(7'd48);
                1: write_fill_limit(7'd64);
                2: write_fill_limit(7'd5);
                3: write_fill_limit(7'd127);
                4: write_fill_limit(7'($urandom_range(0, 127)));
                default: write_fill_limit(7'd32);
            endcase
            send_word('{ACT_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}});
            for (int n = 0; n < 310; ) begin
                burst = (phase == 3) ? 310 : $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 310; b++, n++) begin
                    pick = $urandom_range(0, 99);
                    w.value_in = {$urandom, $urandom};
                    if (pick < 2) w.action = ACT_CLEAR;
                    else if (pick < 4) w.action = ACT_SPARE;
                    else if (pick < 55) w.action = ACT_INSERT;
                    else w.action = ACT_FIND;
                    if (key_pool.size() != 0 && $urandom_range(0, 1))
                        w.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    else
                        w.key = random_key();
                    key_pool.push_back(w.key);
                    if (key_pool.size() > 80) void'(key_pool.pop_front());
                    send_word(w);
                end
                gap = (phase == 3) ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        drain_responses();
        if (mismatches == 0) begin
            $display("hash_table_linear_probe_core verification clean");
        end else begin
            $display("hash_table_linear_probe_core verification failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("hash_table_linear_probe_core verification failed");
        $finish;
    end

endmodule
